[rtl/hpq_pkg.sv]
package hpq_pkg;

	localparam int CAPACITY_DEF = 1024;

	// operation codes carried on mode
	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_EXTRACT = 2'd1;
	localparam logic [1:0] MODE_UPDATE  = 2'd2;

	// result status codes
	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_EMPTY    = 3'd1;
	localparam logic [2:0] STATUS_FULL     = 3'd2;
	localparam logic [2:0] STATUS_REJECTED = 3'd3;
	localparam logic [2:0] STATUS_RANGE    = 3'd4;

	typedef struct packed {
		logic signed [63:0] value;
		logic [2:0]         status;
		logic [10:0]        count;
	} res_t;

	// true if key a belongs strictly nearer the top than key b
	function automatic logic nearer_top(input logic signed [63:0] a,
		input logic signed [63:0] b, input logic is_max);
		return is_max ? (a > b) : (a < b);
	endfunction

endpackage

[rtl/binary_heap_priority_queue.sv]
// binary heap priority queue of signed 64-bit keys, max or min heap
//
// input channel (in_valid/in_ready): mode, item_value, slot_index.
//   insert appends a key and sifts it up, extract returns the top key and
//   sifts the last key down from the root, update replaces the key at a
//   slot unless it would move away from the top, and sifts it up.
// output channel (out_valid/out_ready): result_value, status,
//   element_count, one result per input transfer, in order.
// config: cfg_we writes cfg_wdata into heap_is_max (1 max, 0 min); write
//   only while the block is idle.
// keys live in one memory with registered reads and two read ports; each
//   sift level is one pass through the sift state. insert, errors and unused
//   modes give their result on the transfer itself, extract and update once
//   the read of the stored key returns.
// results pass through a pending register and an output register, so the
//   next item is taken while a finished result waits on out_ready. a
//   stalled receiver holds at most one pending result, then in_ready drops.
// reset clears the key count, heap_is_max and both valid flags; the
//   memory needs no clearing since only keys from slots below the count are used.
module binary_heap_priority_queue
	import hpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [63:0] item_value,
	input  logic [9:0]         slot_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] result_value,
	output logic [2:0]         status,
	output logic [10:0]        element_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic               heap_is_max_q;
	logic               idle;
	logic               start;
	logic               res_valid;
	res_t               res;
	logic               pend_q;
	res_t               pend_res_q;
	logic               out_valid_q;
	res_t               out_res_q;
	logic               out_free;

	// memory port
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [63:0] mem_wdata;
	logic [AW-1:0]      mem_raddr0;
	logic [AW-1:0]      mem_raddr1;
	logic signed [63:0] mem_rdata0;
	logic signed [63:0] mem_rdata1;

	// heap sense register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_is_max_q <= 1'b0;
		end else if (cfg_we) begin
			heap_is_max_q <= cfg_wdata;
		end
	end

	// a new item only when the sequencer is idle and no result is pending
	assign in_ready = idle && !pend_q;
	assign start    = in_valid && in_ready;

	hpq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.heap_is_max (heap_is_max_q),
		.start       (start),
		.mode        (mode),
		.item_value  (item_value),
		.slot_index  (slot_index),
		.idle        (idle),
		.res_valid   (res_valid),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr0  (mem_raddr0),
		.mem_raddr1  (mem_raddr1),
		.mem_rdata0  (mem_rdata0),
		.mem_rdata1  (mem_rdata1)
	);

	hpq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr0 (mem_raddr0),
		.raddr1 (mem_raddr1),
		.rdata0 (mem_rdata0),
		.rdata1 (mem_rdata1)
	);

	// output register is free when empty or its transfer happens now
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (res_valid) begin
				pend_q <= 1'b1;
			end else if (pend_q && out_free) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			pend_res_q <= res;
		end
		if (pend_q && out_free) begin
			out_res_q <= pend_res_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_value  = out_res_q.value;
	assign status        = out_res_q.status;
	assign element_count = out_res_q.count;

endmodule

[rtl/hpq_mem.sv]
module hpq_mem
	import hpq_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [63:0]   wdata,
	input  logic [AW-1:0]        raddr0,
	input  logic [AW-1:0]        raddr1,
	output logic signed [63:0]   rdata0,
	output logic signed [63:0]   rdata1
);

	logic signed [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

[rtl/hpq_ctrl.sv]
module hpq_ctrl
	import hpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               heap_is_max,
	input  logic               start,
	input  logic [1:0]         mode,
	input  logic signed [63:0] item_value,
	input  logic [9:0]         slot_index,
	output logic               idle,
	output logic               res_valid,
	output res_t               res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic signed [63:0] mem_wdata,
	output logic [AW-1:0]      mem_raddr0,
	output logic [AW-1:0]      mem_raddr1,
	input  logic signed [63:0] mem_rdata0,
	input  logic signed [63:0] mem_rdata1
);

	localparam int LW   = AW + 2;
	localparam int CMPW = (CW > 10) ? CW : 10;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXT  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_UP   = 3'd3;
	localparam logic [2:0] ST_DN   = 3'd4;

	logic [2:0]         state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [AW-1:0]      idx_q, idx_d;
	logic signed [63:0] key_q, key_d;

	logic [AW-1:0]      up_idx;
	logic               go_up;
	logic [LW-1:0]      l_idx, r_idx;
	logic               l_ok, r_ok, take_l, take_r, r_vs;
	logic [AW-1:0]      best_idx;
	logic signed [63:0] best_val;
	logic               slot_ok;

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] i);
		logic [AW-1:0] t;
		t = i - AW'(1);
		return t >> 1;
	endfunction

	function automatic logic [AW-1:0] left_of(input logic [AW-1:0] i);
		return AW'({i, 1'b1});
	endfunction

	function automatic logic [AW-1:0] right_of(input logic [AW-1:0] i);
		return AW'({1'b0, i, 1'b1} + LW'(1));
	endfunction

	// sift up: hole at idx_q, parent key in rdata0
	assign up_idx = parent_of(idx_q);
	assign go_up  = (idx_q != '0) && nearer_top(key_q, mem_rdata0, heap_is_max);

	// sift down: hole at idx_q, children in rdata0 / rdata1
	assign l_idx  = {1'b0, idx_q, 1'b1};
	assign r_idx  = l_idx + LW'(1);
	assign l_ok   = l_idx < LW'(count_q);
	assign r_ok   = r_idx < LW'(count_q);
	assign take_l = l_ok && nearer_top(mem_rdata0, key_q, heap_is_max);
	assign r_vs   = take_l ? nearer_top(mem_rdata1, mem_rdata0, heap_is_max)
		: nearer_top(mem_rdata1, key_q, heap_is_max);
	assign take_r = r_ok && r_vs;

	always_comb begin
		best_idx = AW'(l_idx);
		best_val = mem_rdata0;
		if (take_r) begin
			best_idx = AW'(r_idx);
			best_val = mem_rdata1;
		end
	end

	assign slot_ok = CMPW'(slot_index) < CMPW'(count_q);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		key_d      = key_q;
		mem_we     = 1'b0;
		mem_waddr  = idx_q;
		mem_wdata  = key_q;
		mem_raddr0 = '0;
		mem_raddr1 = '0;
		res_valid  = 1'b0;
		res.value  = '0;
		res.status = STATUS_OK;
		res.count  = 11'(count_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_valid = 1'b1;
					unique case (mode)
						MODE_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								res.status = STATUS_FULL;
							end else begin
								count_d    = count_q + CW'(1);
								idx_d      = AW'(count_q);
								key_d      = item_value;
								mem_raddr0 = parent_of(AW'(count_q));
								res.count  = 11'(count_d);
								state_d    = ST_UP;
							end
						end
						MODE_EXTRACT: begin
							if (count_q == '0) begin
								res.status = STATUS_EMPTY;
							end else begin
								// result waits for the root read
								res_valid  = 1'b0;
								count_d    = count_q - CW'(1);
								mem_raddr0 = '0;
								mem_raddr1 = AW'(count_d);
								state_d    = ST_EXT;
							end
						end
						MODE_UPDATE: begin
							if (!slot_ok) begin
								res.status = STATUS_RANGE;
							end else begin
								res_valid  = 1'b0;
								idx_d      = AW'(slot_index);
								key_d      = item_value;
								mem_raddr0 = AW'(slot_index);
								state_d    = ST_UPD;
							end
						end
						default: begin
							res.status = STATUS_OK;
						end
					endcase
				end
			end
			ST_EXT: begin
				res_valid = 1'b1;
				res.value = mem_rdata0;
				if (count_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					// last key becomes the moving key, hole at the root
					key_d      = mem_rdata1;
					idx_d      = '0;
					mem_raddr0 = left_of('0);
					mem_raddr1 = right_of('0);
					state_d    = ST_DN;
				end
			end
			ST_UPD: begin
				res_valid = 1'b1;
				if (nearer_top(mem_rdata0, key_q, heap_is_max)) begin
					res.status = STATUS_REJECTED;
					state_d    = ST_IDLE;
				end else begin
					mem_raddr0 = up_idx;
					state_d    = ST_UP;
				end
			end
			ST_UP: begin
				mem_we = 1'b1;
				if (go_up) begin
					mem_wdata  = mem_rdata0;
					idx_d      = up_idx;
					mem_raddr0 = parent_of(up_idx);
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DN: begin
				mem_we = 1'b1;
				if (take_l || take_r) begin
					mem_wdata  = best_val;
					idx_d      = best_idx;
					mem_raddr0 = left_of(best_idx);
					mem_raddr1 = right_of(best_idx);
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		key_q <= key_d;
	end

	assign idle = (state_q == ST_IDLE);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count above capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) < count_q))
		else $error("heap write outside held keys");

	a_sift_down_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DN) |-> (count_q != '0))
		else $error("sift down on empty heap");

	a_count_steady_in_sift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP || state_q == ST_DN) |=> $stable(count_q))
		else $error("key count moved during a sift");

endmodule
